@@ rtl/core/dvd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvd_pkg
// Shared widths, codes, reset values and calendar tables for the date
// validate and difference unit.
// ----------------------------------------------------------------------------
package dvd_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int DN_W     = 22;
  localparam int DIFF_W   = 23;
  localparam int STATUS_W = 2;
  localparam int ORDER_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 14;
  localparam int SUM_W    = 24;
  localparam int MOFS_W   = 9;
  localparam int LEN_W    = 5;

  // year / 100 as (year * RECIP_100) >> RECIP_SHIFT, exact for 14-bit years
  localparam int RECIP_W     = 13;
  localparam int PROD_W      = YEAR_W + RECIP_W;
  localparam int RECIP_SHIFT = 19;
  localparam int Q100_W      = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

  localparam logic [DN_W-1:0]  DN_MAX  = 22'd4194303;
  localparam logic [SUM_W-1:0] DN_BIAS = 24'd306;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_YEAR_ERR  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MONTH_ERR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DAY_ERR   = 2'd3;

  localparam logic [ORDER_W-1:0] ORD_LESS    = 2'd0;
  localparam logic [ORDER_W-1:0] ORD_EQUAL   = 2'd1;
  localparam logic [ORDER_W-1:0] ORD_GREATER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_YEAR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUR_YEAR   = 1'd1;

  localparam logic [YEAR_W-1:0] FLOOR_YEAR_RST = 14'd1500;
  localparam logic [YEAR_W-1:0] CUR_YEAR_RST   = 14'd2022;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_SHIFT = 4'd12;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // days in a common-year month
  function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [LEN_W-1:0] len;
    begin
      unique case (m)
        4'd2:                   len = 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
        default:                len = 5'd31;
      endcase
      return len;
    end
  endfunction

  // (153 * tm - 457) / 5 for the March-based month tm in 3..14
  function automatic logic [MOFS_W-1:0] month_offset(input logic [MONTH_W-1:0] tm);
    logic [MOFS_W-1:0] ofs;
    begin
      unique case (tm)
        4'd4:    ofs = 9'd31;
        4'd5:    ofs = 9'd61;
        4'd6:    ofs = 9'd92;
        4'd7:    ofs = 9'd122;
        4'd8:    ofs = 9'd153;
        4'd9:    ofs = 9'd184;
        4'd10:   ofs = 9'd214;
        4'd11:   ofs = 9'd245;
        4'd12:   ofs = 9'd275;
        4'd13:   ofs = 9'd306;
        4'd14:   ofs = 9'd337;
        default: ofs = 9'd0;
      endcase
      return ofs;
    end
  endfunction

endpackage

@@ rtl/core/dvd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvd_in_if / dvd_out_if
// Valid/ready channels for date pairs and for comparison results.
// ----------------------------------------------------------------------------
interface dvd_in_if;
  logic                             valid;
  logic                             ready;
  logic [dvd_pkg::YEAR_W-1:0]  year_a;
  logic [dvd_pkg::MONTH_W-1:0] month_a;
  logic [dvd_pkg::DAY_W-1:0]   day_a;
  logic [dvd_pkg::YEAR_W-1:0]  year_b;
  logic [dvd_pkg::MONTH_W-1:0] month_b;
  logic [dvd_pkg::DAY_W-1:0]   day_b;

  modport source (output valid, year_a, month_a, day_a, year_b, month_b, day_b,
                  input ready);
  modport sink (input valid, year_a, month_a, day_a, year_b, month_b, day_b,
                output ready);
endinterface

interface dvd_out_if;
  logic                               valid;
  logic                               ready;
  logic [dvd_pkg::STATUS_W-1:0]  status_a;
  logic [dvd_pkg::STATUS_W-1:0]  status_b;
  logic [dvd_pkg::DN_W-1:0]      day_number_a;
  logic [dvd_pkg::DN_W-1:0]      day_number_b;
  logic signed [dvd_pkg::DIFF_W-1:0] day_difference;
  logic [dvd_pkg::ORDER_W-1:0]   order;

  modport source (output valid, status_a, status_b, day_number_a, day_number_b,
                  day_difference, order, input ready);
  modport sink (input valid, status_a, status_b, day_number_a, day_number_b,
                day_difference, order, output ready);
endinterface

@@ rtl/core/date_validate_and_difference_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_validate_and_difference_unit
// Validates two Gregorian dates and reports their day numbers and difference.
// ----------------------------------------------------------------------------
// in_chan takes one date pair per transfer; out_chan gives one result per
// pair: both status codes, both Rata Die day numbers (0 for an invalid date),
// the signed difference a - b and the order code.
// cfg_we / cfg_index / cfg_wdata write the lowest accepted year and
// current_year; write them only while no pair is in flight.
// Throughput is one pair per cycle while out_chan.ready stays high, through
// four register stages (range and reciprocal multiply, leap and
// month-length check with the year sum, day-number add and saturation,
// difference and compare).
// Each stage holds its item while the next one is full and stalled and
// advances into any bubble, so a stalled receiver fills at most four stages
// before in_chan.ready drops; nothing is dropped or repeated.
// Synchronous reset clears all valid bits and restores the lowest accepted
// year to 1500 and current_year to 2022.
// ----------------------------------------------------------------------------
module date_validate_and_difference_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  dvd_in_if.sink                            in_chan,
  dvd_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [dvd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dvd_pkg::CFG_W-1:0]         cfg_wdata
);

  logic [dvd_pkg::YEAR_W-1:0] floor_year_r, cur_year_r;
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;
  dvd_pkg::stage_en_t en;

  logic [dvd_pkg::STATUS_W-1:0] st_a, st_b;
  logic [dvd_pkg::DN_W-1:0]     dn_a, dn_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_year_r <= dvd_pkg::FLOOR_YEAR_RST;
      cur_year_r   <= dvd_pkg::CUR_YEAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dvd_pkg::CFG_FLOOR_YEAR: floor_year_r <= cfg_wdata;
        dvd_pkg::CFG_CUR_YEAR:   cur_year_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en4 = !v4_r || out_chan.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign en.s1 = en1;
  assign en.s2 = en2;
  assign en.s3 = en3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_chan.valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
    end
  end

  assign in_chan.ready  = en1;
  assign out_chan.valid = v4_r;

  dvd_date_pipe u_pipe_a (
    .clk        (clk),
    .en         (en),
    .floor_year (floor_year_r),
    .cur_year   (cur_year_r),
    .year       (in_chan.year_a),
    .month      (in_chan.month_a),
    .day        (in_chan.day_a),
    .status     (st_a),
    .day_number (dn_a)
  );

  dvd_date_pipe u_pipe_b (
    .clk        (clk),
    .en         (en),
    .floor_year (floor_year_r),
    .cur_year   (cur_year_r),
    .year       (in_chan.year_b),
    .month      (in_chan.month_b),
    .day        (in_chan.day_b),
    .status     (st_b),
    .day_number (dn_b)
  );

  dvd_cmp u_cmp (
    .clk            (clk),
    .en             (en4),
    .st_a           (st_a),
    .st_b           (st_b),
    .dn_a           (dn_a),
    .dn_b           (dn_b),
    .status_a       (out_chan.status_a),
    .status_b       (out_chan.status_b),
    .day_number_a   (out_chan.day_number_a),
    .day_number_b   (out_chan.day_number_b),
    .day_difference (out_chan.day_difference),
    .order          (out_chan.order)
  );

endmodule

@@ rtl/core/dvd_date_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvd_date_pipe
// Three-stage check and Rata Die day number of one Gregorian date.
// ----------------------------------------------------------------------------
module dvd_date_pipe (
  input  logic                             clk,
  input  dvd_pkg::stage_en_t               en,
  input  logic [dvd_pkg::YEAR_W-1:0]       floor_year,
  input  logic [dvd_pkg::YEAR_W-1:0]       cur_year,
  input  logic [dvd_pkg::YEAR_W-1:0]       year,
  input  logic [dvd_pkg::MONTH_W-1:0]      month,
  input  logic [dvd_pkg::DAY_W-1:0]        day,
  output logic [dvd_pkg::STATUS_W-1:0]     status,
  output logic [dvd_pkg::DN_W-1:0]         day_number
);

  // stage 1
  logic [dvd_pkg::YEAR_W-1:0]  y1_r;
  logic [dvd_pkg::MONTH_W-1:0] m1_r;
  logic [dvd_pkg::DAY_W-1:0]   d1_r;
  logic                        yerr1_r, yerr1_nxt;
  logic                        merr1_r, merr1_nxt;
  logic [dvd_pkg::YEAR_W-1:0]  ty1_r, ty1_nxt;
  logic [dvd_pkg::MONTH_W-1:0] tm1_r, tm1_nxt;
  logic [dvd_pkg::PROD_W-1:0]  prod_y1_r, prod_y1_nxt;
  logic [dvd_pkg::PROD_W-1:0]  prod_t1_r, prod_t1_nxt;
  logic                        early;

  // stage 2
  logic [dvd_pkg::STATUS_W-1:0] st2_r, st2_nxt;
  logic [dvd_pkg::SUM_W-1:0]    sum2_r, sum2_nxt;
  logic [dvd_pkg::MOFS_W-1:0]   mofs2_r, mofs2_nxt;
  logic [dvd_pkg::DAY_W-1:0]    d2_r;
  logic [dvd_pkg::Q100_W-1:0]   q100y, q100t;
  logic [dvd_pkg::YEAR_W-1:0]   r100y;
  logic                         leap;
  logic [dvd_pkg::LEN_W-1:0]    lim;
  logic                         dbad;

  // stage 3
  logic [dvd_pkg::STATUS_W-1:0] st3_r;
  logic [dvd_pkg::DN_W-1:0]     dn3_r, dn3_nxt;
  logic [dvd_pkg::SUM_W-1:0]    v;

  assign yerr1_nxt = (year == '0) || (year < floor_year) ||
                     ({1'b0, year} > ({1'b0, cur_year} + 15'd1));
  assign merr1_nxt = (month < dvd_pkg::MONTH_JAN) || (month > dvd_pkg::MONTH_DEC);
  assign early     = (month < dvd_pkg::MONTH_MAR);
  assign ty1_nxt   = early ? (year - dvd_pkg::YEAR_W'(1)) : year;
  assign tm1_nxt   = early ? (month + dvd_pkg::MONTH_SHIFT) : month;
  assign prod_y1_nxt = dvd_pkg::PROD_W'(year) * dvd_pkg::PROD_W'(dvd_pkg::RECIP_100);
  assign prod_t1_nxt = dvd_pkg::PROD_W'(ty1_nxt) * dvd_pkg::PROD_W'(dvd_pkg::RECIP_100);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      y1_r      <= year;
      m1_r      <= month;
      d1_r      <= day;
      yerr1_r   <= yerr1_nxt;
      merr1_r   <= merr1_nxt;
      ty1_r     <= ty1_nxt;
      tm1_r     <= tm1_nxt;
      prod_y1_r <= prod_y1_nxt;
      prod_t1_r <= prod_t1_nxt;
    end
  end

  assign q100y = prod_y1_r[dvd_pkg::PROD_W-1:dvd_pkg::RECIP_SHIFT];
  assign q100t = prod_t1_r[dvd_pkg::PROD_W-1:dvd_pkg::RECIP_SHIFT];
  assign r100y = y1_r - (dvd_pkg::YEAR_W'(q100y) * dvd_pkg::YEAR_W'(100));
  assign leap  = (y1_r[1:0] == 2'd0) && ((r100y != '0) || (q100y[1:0] == 2'd0));
  assign lim   = dvd_pkg::month_len(m1_r) +
                 dvd_pkg::LEN_W'((m1_r == dvd_pkg::MONTH_FEB) && leap);
  assign dbad  = (d1_r == '0) || (d1_r > lim);

  always_comb begin
    priority if (yerr1_r) begin
      st2_nxt = dvd_pkg::ST_YEAR_ERR;
    end else if (merr1_r) begin
      st2_nxt = dvd_pkg::ST_MONTH_ERR;
    end else if (dbad) begin
      st2_nxt = dvd_pkg::ST_DAY_ERR;
    end else begin
      st2_nxt = dvd_pkg::ST_OK;
    end
  end

  assign sum2_nxt = (dvd_pkg::SUM_W'(ty1_r) * dvd_pkg::SUM_W'(365))
                  + dvd_pkg::SUM_W'(ty1_r >> 2)
                  - dvd_pkg::SUM_W'(q100t)
                  + dvd_pkg::SUM_W'(q100t >> 2);
  assign mofs2_nxt = dvd_pkg::month_offset(tm1_r);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      st2_r   <= st2_nxt;
      sum2_r  <= sum2_nxt;
      mofs2_r <= mofs2_nxt;
      d2_r    <= d1_r;
    end
  end

  assign v = sum2_r + dvd_pkg::SUM_W'(mofs2_r) + dvd_pkg::SUM_W'(d2_r) - dvd_pkg::DN_BIAS;

  always_comb begin
    priority if (st2_r != dvd_pkg::ST_OK) begin
      dn3_nxt = '0;
    end else if (v > dvd_pkg::SUM_W'(dvd_pkg::DN_MAX)) begin
      dn3_nxt = dvd_pkg::DN_MAX;
    end else begin
      dn3_nxt = v[dvd_pkg::DN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      st3_r <= st2_r;
      dn3_r <= dn3_nxt;
    end
  end

  assign status     = st3_r;
  assign day_number = dn3_r;

endmodule

@@ rtl/core/dvd_cmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvd_cmp
// Output stage: signed day difference and order code of two day numbers.
// ----------------------------------------------------------------------------
module dvd_cmp (
  input  logic                               clk,
  input  logic                               en,
  input  logic [dvd_pkg::STATUS_W-1:0]       st_a,
  input  logic [dvd_pkg::STATUS_W-1:0]       st_b,
  input  logic [dvd_pkg::DN_W-1:0]           dn_a,
  input  logic [dvd_pkg::DN_W-1:0]           dn_b,
  output logic [dvd_pkg::STATUS_W-1:0]       status_a,
  output logic [dvd_pkg::STATUS_W-1:0]       status_b,
  output logic [dvd_pkg::DN_W-1:0]           day_number_a,
  output logic [dvd_pkg::DN_W-1:0]           day_number_b,
  output logic signed [dvd_pkg::DIFF_W-1:0]  day_difference,
  output logic [dvd_pkg::ORDER_W-1:0]        order
);

  logic [dvd_pkg::STATUS_W-1:0]      st_a_r, st_b_r;
  logic [dvd_pkg::DN_W-1:0]          dn_a_r, dn_b_r;
  logic [dvd_pkg::DIFF_W-1:0]        diff_r, diff_nxt;
  logic [dvd_pkg::ORDER_W-1:0]       ord_r, ord_nxt;

  assign diff_nxt = {1'b0, dn_a} - {1'b0, dn_b};

  always_comb begin
    priority if (dn_a < dn_b) begin
      ord_nxt = dvd_pkg::ORD_LESS;
    end else if (dn_a == dn_b) begin
      ord_nxt = dvd_pkg::ORD_EQUAL;
    end else begin
      ord_nxt = dvd_pkg::ORD_GREATER;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_a_r <= st_a;
      st_b_r <= st_b;
      dn_a_r <= dn_a;
      dn_b_r <= dn_b;
      diff_r <= diff_nxt;
      ord_r  <= ord_nxt;
    end
  end

  assign status_a       = st_a_r;
  assign status_b       = st_b_r;
  assign day_number_a   = dn_a_r;
  assign day_number_b   = dn_b_r;
  assign day_difference = signed'(diff_r);
  assign order          = ord_r;

endmodule

@@ rtl/core/dvd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvd_checker
// Port-level checks of result consistency, bound to the top level.
// ----------------------------------------------------------------------------
module dvd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic [dvd_pkg::STATUS_W-1:0]      status_a,
  input logic [dvd_pkg::STATUS_W-1:0]      status_b,
  input logic [dvd_pkg::DN_W-1:0]          day_number_a,
  input logic [dvd_pkg::DN_W-1:0]          day_number_b,
  input logic [dvd_pkg::DIFF_W-1:0]        day_difference,
  input logic [dvd_pkg::ORDER_W-1:0]       order
);

  a_status_a_dn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((status_a == dvd_pkg::ST_OK) == (day_number_a != '0)))
    else $error("status_a disagrees with day_number_a");

  a_status_b_dn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((status_b == dvd_pkg::ST_OK) == (day_number_b != '0)))
    else $error("status_b disagrees with day_number_b");

  a_equal_diff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((order == dvd_pkg::ORD_EQUAL) == (day_difference == '0)))
    else $error("order equal disagrees with difference");

  a_less_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((order == dvd_pkg::ORD_LESS) == day_difference[dvd_pkg::DIFF_W-1]))
    else $error("order less disagrees with difference sign");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind date_validate_and_difference_unit dvd_checker u_dvd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .status_a       (out_chan.status_a),
  .status_b       (out_chan.status_b),
  .day_number_a   (out_chan.day_number_a),
  .day_number_b   (out_chan.day_number_b),
  .day_difference (out_chan.day_difference),
  .order          (out_chan.order)
);
